/* hw/rtl/stfs_pkg.sv */
// Package for the slot table with free stack: field widths, command and
// status codes, parameter defaults and the free-stack control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stfs_pkg;

  // Parameter defaults
  localparam int ENTITIES_DEF = 1024;
  localparam int RECORDS_DEF  = 1024;
  localparam int PAYLOAD_DEF  = 64;

  // Fixed port field widths
  localparam int CMD_W    = 2;
  localparam int ENT_W    = 10;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 10;
  localparam int LIVE_W   = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVER    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd5;

  // Map entry valid flag for an entity holding no record
  localparam logic NO_ATTACH = 1'b0;

  // Free-stack control from the sequencer
  typedef struct packed {
    logic start;  // request accepted: fetch top of stack
    logic pop;    // allocate the candidate slot
    logic push;   // return a slot to the stack
  } alloc_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/stfs_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module stfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read that holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/stfs_alloc.sv */
// Slot allocator: LIFO free stack in RAM plus the never-used high-water mark.
// Depends on stfs_pkg and stfs_ram.
`timescale 1ns / 1ps
`default_nettype none

module stfs_alloc #(
  parameter int RECORDS = stfs_pkg::RECORDS_DEF,
  localparam int SW = $clog2(RECORDS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire stfs_pkg::alloc_ctl_t ctl,
  input  wire logic [SW-1:0]       push_slot,
  output logic                     can_alloc,
  output logic      [SW-1:0]       cand_slot
);

  import stfs_pkg::*;

  localparam int CW = $clog2(RECORDS + 1);

  logic [CW-1:0] free_top;
  logic [CW-1:0] high_water;
  logic [SW-1:0] stack_rdata;
  logic          stack_we;
  logic          stack_nonempty;
  logic [CW-1:0] top_less1;

  assign stack_nonempty = (free_top != '0);
  assign top_less1      = free_top - 1'b1;
  assign stack_we       = ctl.push && (free_top < CW'(RECORDS));

  // Free stack storage; top entry fetched when a request is accepted
  stfs_ram #(
    .WIDTH (SW),
    .DEPTH (RECORDS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (free_top[SW-1:0]),
    .wdata (push_slot),
    .re    (ctl.start),
    .raddr (top_less1[SW-1:0]),
    .rdata (stack_rdata)
  );

  // Reuse a freed slot first, else the next never-used one
  assign can_alloc = stack_nonempty || (high_water < CW'(RECORDS));
  assign cand_slot = stack_nonempty ? stack_rdata : high_water[SW-1:0];

  // Stack pointer and high-water mark
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top   <= '0;
      high_water <= '0;
    end else begin
      if (ctl.pop) begin
        if (stack_nonempty) begin
          free_top <= top_less1;
        end else begin
          high_water <= high_water + 1'b1;
        end
      end else if (stack_we) begin
        free_top <= free_top + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/slot_table_with_free_stack_top.sv */
// Slot table with LIFO free list: top level, sequencer, map and record RAMs.
// Depends on stfs_pkg, stfs_ram and stfs_alloc.
//
// Usage:
//   Requests arrive on the in_valid/in_ready channel carrying cmd, entity
//   and record_data; one result per request leaves on out_valid/out_ready
//   with status, slot, record_out and live_count.
//   Set and clear go from acceptance through a map read, then decide and
//   write back; a look up that hits adds a record read, as the record
//   read depends on the slot found in the map. The next request is taken
//   in the cycle after the result is registered, so the block takes no
//   new request while the one before it is still in progress.
//   After reset the map is swept to "no record", one entry a cycle over
//   all ENTITIES entries (1024 by default); in_ready stays low meanwhile.
//   A result waits in the output register while a new request is
//   accepted; if it is still not taken when the next result is ready, the
//   sequencer holds that request, with no writes done, until it is.
`timescale 1ns / 1ps
`default_nettype none

module slot_table_with_free_stack_top #(
  parameter int ENTITIES     = stfs_pkg::ENTITIES_DEF,
  parameter int RECORDS      = stfs_pkg::RECORDS_DEF,
  parameter int PAYLOAD_BITS = stfs_pkg::PAYLOAD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [stfs_pkg::CMD_W-1:0]     cmd,
  input  wire logic [stfs_pkg::ENT_W-1:0]     entity,
  input  wire logic [stfs_pkg::DATA_W-1:0]    record_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [stfs_pkg::STATUS_W-1:0]  status,
  output logic      [stfs_pkg::SLOT_W-1:0]    slot,
  output logic      [stfs_pkg::DATA_W-1:0]    record_out,
  output logic      [stfs_pkg::LIVE_W-1:0]    live_count
);

  import stfs_pkg::*;

  localparam int EA = $clog2(ENTITIES);
  localparam int SW = $clog2(RECORDS);
  localparam int CW = $clog2(RECORDS + 1);
  localparam int PB = PAYLOAD_BITS;

  // Sequencer states
  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_LOOK = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [EA-1:0]    clr_addr;

  // Latched request
  logic [CMD_W-1:0] req_cmd;
  logic [ENT_W-1:0] req_ent;
  logic [PB-1:0]    req_data;
  logic             req_bad;

  logic [CW-1:0]    live_total;
  logic [CW-1:0]    live_next;

  logic             accept;
  logic             go;

  // Map RAM: {valid, slot}
  logic             map_we;
  logic [EA-1:0]    map_waddr;
  logic [SW:0]      map_wdata;
  logic [SW:0]      map_rdata;
  logic             map_valid;
  logic [SW-1:0]    map_slot;

  // Record RAM
  logic             rec_we;
  logic [SW-1:0]    rec_waddr;
  logic             rec_re;
  logic [PB-1:0]    rec_rdata;

  // Allocator
  alloc_ctl_t       actl;
  logic             can_alloc;
  logic [SW-1:0]    cand_slot;

  // Result to load
  logic                res_load;
  logic [STATUS_W-1:0] res_status;
  logic [SW-1:0]       res_slot;
  logic [PB-1:0]       res_rec;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign go        = !out_valid || out_ready;
  assign map_valid = map_rdata[SW];
  assign map_slot  = map_rdata[SW-1:0];

  stfs_ram #(
    .WIDTH (SW + 1),
    .DEPTH (ENTITIES)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (EA'(entity)),
    .rdata (map_rdata)
  );

  stfs_ram #(
    .WIDTH (PB),
    .DEPTH (RECORDS)
  ) u_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (req_data),
    .re    (rec_re),
    .raddr (map_slot),
    .rdata (rec_rdata)
  );

  stfs_alloc #(
    .RECORDS (RECORDS)
  ) u_alloc (
    .clk       (clk),
    .rst       (rst),
    .ctl       (actl),
    .push_slot (map_slot),
    .can_alloc (can_alloc),
    .cand_slot (cand_slot)
  );

  // Map clear sweep after reset, then decide and write back
  always_comb begin
    state_next = state;
    map_we     = 1'b0;
    map_waddr  = EA'(req_ent);
    map_wdata  = {NO_ATTACH, {SW{1'b0}}};
    rec_we     = 1'b0;
    rec_waddr  = map_slot;
    rec_re     = 1'b0;
    actl.start = accept;
    actl.pop   = 1'b0;
    actl.push  = 1'b0;
    res_load   = 1'b0;
    res_status = ST_BAD;
    res_slot   = '0;
    res_rec    = '0;
    live_next  = live_total;
    case (state)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        if (clr_addr == EA'(ENTITIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          state_next = S_IDLE;
          res_load   = 1'b1;
          if (req_bad) begin
            res_status = ST_BAD;
          end else begin
            case (req_cmd)
              CMD_SET: begin
                if (map_valid) begin
                  // overwrite in place
                  rec_we     = 1'b1;
                  res_status = ST_OVER;
                  res_slot   = map_slot;
                end else if (can_alloc) begin
                  rec_we     = 1'b1;
                  rec_waddr  = cand_slot;
                  map_we     = 1'b1;
                  map_wdata  = {1'b1, cand_slot};
                  actl.pop   = 1'b1;
                  live_next  = live_total + 1'b1;
                  res_status = ST_NEW;
                  res_slot   = cand_slot;
                end else begin
                  res_status = ST_FULL;
                end
              end
              CMD_CLEAR: begin
                if (map_valid) begin
                  map_we     = 1'b1;
                  actl.push  = 1'b1;
                  if (live_total != '0) begin
                    live_next = live_total - 1'b1;
                  end
                  res_status = ST_CLEARED;
                  res_slot   = map_slot;
                end else begin
                  res_status = ST_ABSENT;
                end
              end
              CMD_GET: begin
                if (map_valid) begin
                  // fetch the record; the result is loaded from S_LOOK
                  rec_re     = 1'b1;
                  res_load   = 1'b0;
                  state_next = S_LOOK;
                end else begin
                  res_status = ST_ABSENT;
                end
              end
              default: begin
                res_status = ST_BAD;
              end
            endcase
          end
        end
      end
      S_LOOK: begin
        if (go) begin
          state_next = S_IDLE;
          res_load   = 1'b1;
          res_status = ST_OVER;
          res_slot   = map_slot;
          res_rec    = rec_rdata;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_addr   <= '0;
      live_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      live_total <= live_next;
      if (state == S_CLR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd  <= cmd;
      req_ent  <= entity;
      req_data <= PB'(record_data);
      req_bad  <= (32'(entity) >= ENTITIES);
    end
    if (res_load) begin
      status     <= res_status;
      slot       <= SLOT_W'(res_slot);
      record_out <= DATA_W'(res_rec);
      live_count <= LIVE_W'(live_next);
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the slot table with LIFO free stack: directed and random
// requests checked against an in-bench model of the map, store and stack.
// Depends on stfs_pkg and slot_table_with_free_stack_top.
`timescale 1ns / 1ps

module tb_top;
  import stfs_pkg::*;

  localparam int ENTITIES       = ENTITIES_DEF;
  localparam int RECORDS        = RECORDS_DEF;
  localparam int HOT_ENTITIES   = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 8;
  localparam int MAX_PRINTS     = 100;

  // Command code the block answers with ST_BAD, changing nothing
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   rec_data;
    logic [LIVE_W-1:0]   live;
  } table_result_t;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd         = CMD_GET;
  logic [ENT_W-1:0]    entity      = '0;
  logic [DATA_W-1:0]   record_data = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [DATA_W-1:0]   record_out;
  logic [LIVE_W-1:0]   live_count;

  // Model state of the table
  bit                ent_mapped  [ENTITIES];
  bit [SLOT_W-1:0]   ent_slot    [ENTITIES];
  bit [DATA_W-1:0]   slot_record [RECORDS];
  bit [SLOT_W-1:0]   freed_slots [RECORDS];
  int                freed_count   = 0;
  int                slots_used    = 0;
  int                live_entities = 0;

  table_result_t pending_results[$];
  table_result_t want_res;
  int            fail_count    = 0;
  int            idle_cycles   = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  slot_table_with_free_stack_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entity      (entity),
    .record_data (record_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .slot        (slot),
    .record_out  (record_out),
    .live_count  (live_count)
  );

  always #5 clk = ~clk;

  // Apply one request to the model table and return the result it gives
  function automatic table_result_t apply_command(logic [CMD_W-1:0] c, logic [ENT_W-1:0] e,
                                                  logic [DATA_W-1:0] d);
    table_result_t r;
    logic [SLOT_W-1:0] s;
    r = '0;
    if (int'(e) >= ENTITIES || c == CMD_UNUSED) begin
      r.status = ST_BAD;
    end else if (c == CMD_SET) begin
      if (ent_mapped[e]) begin
        s = ent_slot[e];
        slot_record[s] = d;
        r.status = ST_OVER;
        r.slot = s;
      end else if (freed_count > 0 || slots_used < RECORDS) begin
        // LIFO reuse first, then the next never-used slot
        if (freed_count > 0) begin
          freed_count--;
          s = freed_slots[freed_count];
        end else begin
          s = slots_used[SLOT_W-1:0];
          slots_used++;
        end
        slot_record[s] = d;
        ent_slot[e] = s;
        ent_mapped[e] = 1'b1;
        live_entities++;
        r.status = ST_NEW;
        r.slot = s;
      end else begin
        r.status = ST_FULL;
      end
    end else if (!ent_mapped[e]) begin
      r.status = ST_ABSENT;
    end else begin
      s = ent_slot[e];
      r.slot = s;
      if (c == CMD_CLEAR) begin
        ent_mapped[e] = 1'b0;
        if (freed_count < RECORDS) begin
          freed_slots[freed_count] = s;
          freed_count++;
        end
        if (live_entities > 0) live_entities--;
        r.status = ST_CLEARED;
      end else begin
        r.status = ST_OVER;
        r.rec_data = slot_record[s];
      end
    end
    r.live = live_entities[LIVE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) report_mismatch($sformatf("%s: expected %0h, got %0h", field, want, got));
  endtask

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Predict on each accepted request
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      pending_results.insert(pending_results.size(), apply_command(cmd, entity, record_data));
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want_res = pending_results.pop_front();
        check_field("status", DATA_W'(want_res.status), DATA_W'(status));
        check_field("slot", DATA_W'(want_res.slot), DATA_W'(slot));
        check_field("record_out", want_res.rec_data, record_out);
        check_field("live_count", DATA_W'(want_res.live), DATA_W'(live_count));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL slot_table_with_free_stack_top");
      $finish;
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Offer one request and return at the edge where it is taken
  task automatic send_request(logic [CMD_W-1:0] c, logic [ENT_W-1:0] e, logic [DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    entity      <= e;
    record_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off new requests until every predicted result has arrived
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // Extremes, LIFO reuse, misses and the unused command
  task automatic test_directed_cases();
    send_request(CMD_GET,    10'd0,    '0);
    send_request(CMD_CLEAR,  10'd1023, '0);
    send_request(CMD_SET,    10'd0,    '0);
    send_request(CMD_SET,    10'd1023, '1);
    send_request(CMD_GET,    10'd0,    '1);
    send_request(CMD_GET,    10'd1023, '0);
    send_request(CMD_SET,    10'd0,    64'hAAAA_AAAA_AAAA_AAAA);
    send_request(CMD_GET,    10'd0,    '0);
    send_request(CMD_SET,    10'd512,  64'h5555_5555_5555_5555);
    send_request(CMD_CLEAR,  10'd0,    '0);
    send_request(CMD_GET,    10'd0,    '0);
    send_request(CMD_CLEAR,  10'd0,    '0);
    send_request(CMD_CLEAR,  10'd1023, '0);
    // two pops: the slot freed last comes back first
    send_request(CMD_SET,    10'd5,    64'h8000_0000_0000_0001);
    send_request(CMD_SET,    10'd6,    64'h1);
    send_request(CMD_SET,    10'd7,    rand_data());
    send_request(CMD_GET,    10'd5,    '0);
    send_request(CMD_GET,    10'd6,    '0);
    send_request(CMD_UNUSED, 10'd0,    '0);
    send_request(CMD_UNUSED, 10'd1023, '1);
    send_request(CMD_UNUSED, 10'd5,    '0);
    send_request(CMD_GET,    10'd5,    '0);
    send_request(CMD_SET,    10'd5,    '1);
    send_request(CMD_GET,    10'd512,  '0);
    wait_for_results();
  endtask

  // Mixed traffic, mostly on a small set of entities so that hits are common
  task automatic test_random_traffic(int count);
    int pick;
    logic [CMD_W-1:0] c;
    logic [ENT_W-1:0] e;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) c = CMD_SET;
      else if (pick < 65) c = CMD_CLEAR;
      else if (pick < 95) c = CMD_GET;
      else c = CMD_UNUSED;
      if ($urandom_range(99) < 75) e = ENT_W'($urandom_range(HOT_ENTITIES - 1));
      else e = ENT_W'($urandom_range(ENTITIES - 1));
      send_request(c, e, rand_data());
      if ($urandom_range(99) < 2) wait_for_results();
    end
  endtask

  // Set every entity once in shuffled order: live count and slot use reach the top
  task automatic test_fill_every_entity();
    int order [ENTITIES];
    int j;
    int tmp;
    for (int i = 0; i < ENTITIES; i++) order[i] = i;
    for (int i = ENTITIES - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < ENTITIES; i++) send_request(CMD_SET, ENT_W'(order[i]), rand_data());
  endtask

  // With every slot once used, new sets can only come off the free stack
  task automatic test_clear_heavy_unwind(int count);
    int pick;
    logic [CMD_W-1:0] c;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) c = CMD_CLEAR;
      else if (pick < 80) c = CMD_SET;
      else c = CMD_GET;
      send_request(c, ENT_W'($urandom_range(ENTITIES - 1)), rand_data());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    set_idling(22, 53);
    test_directed_cases();
    test_random_traffic(80);

    set_idling(53, 22);
    test_random_traffic(80);

    set_idling(0, 0);
    test_fill_every_entity();
    test_clear_heavy_unwind(50);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("results still outstanding at the end");
    if (fail_count == 0) begin
      $display("PASS slot_table_with_free_stack_top");
    end else begin
      $display("FAIL slot_table_with_free_stack_top");
    end
    $finish;
  end

endmodule
